/* hdl/busy_time_window_meter_macros.svh */
// Assertion macros shared by the busy-time window meter RTL.
`ifndef BUSY_TIME_WINDOW_METER_MACROS_SVH
`define BUSY_TIME_WINDOW_METER_MACROS_SVH

`ifndef SYNTHESIS

// Check that a condition implies a consequence in the same cycle.
`define BTWM_ASSERT_SAME(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("btwm assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define BTWM_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("btwm assertion failed");

`else

`define BTWM_ASSERT_SAME(label, clk, rst, cond, cons)
`define BTWM_ASSERT_NEXT(label, clk, rst, cond, cons)

`endif

`endif

/* hdl/btwm_pkg.sv */
// Package with constants, types and codes of the busy-time window meter.
`timescale 1ns / 1ps
`default_nettype none
package btwm_pkg;

   localparam int WINDOW_SLOTS     = 16;
   localparam int INTERVAL_SECONDS = 5;

   localparam int TIME_W  = 48;
   localparam int BUSY_W  = 32;
   localparam int AVG_W   = 10;
   localparam int KIND_W  = 2;
   localparam int AVG_MAX = 1000;

   localparam int SLOT_W  = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
   localparam int FILL_W  = $clog2(WINDOW_SLOTS + 1);
   localparam int WSUM_W  = BUSY_W + ((WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 0);
   localparam int DIV_W   = $clog2(INTERVAL_SECONDS * WINDOW_SLOTS + 1);
   localparam int CNT_W   = $clog2(WSUM_W);
   localparam int ALU_W   = TIME_W;

   localparam logic [KIND_W-1:0] KIND_START  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_END    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd3;

   typedef enum logic [0:0] {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      alu_op_type        op;
      logic [ALU_W-1:0]  a;
      logic [ALU_W-1:0]  b;
   } alu_req_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EL_LAST,
      ST_EL_START,
      ST_ADD_IB,
      ST_ADD_TOTAL,
      ST_MAX,
      ST_WIN_SUB,
      ST_WIN_ADD,
      ST_DIV_SET,
      ST_DIV,
      ST_CLAMP,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

/* hdl/btwm_alu.sv */
// Shared add/subtract unit with carry and borrow out.
`timescale 1ns / 1ps
`default_nettype none
module btwm_alu
   import btwm_pkg::*;
(
   input  alu_req_type       alu_req,
   output logic [ALU_W:0]    alu_res
);

   always_comb begin
      unique case (alu_req.op)
         ALU_ADD: alu_res = {1'b0, alu_req.a} + {1'b0, alu_req.b};
         ALU_SUB: alu_res = {1'b0, alu_req.a} - {1'b0, alu_req.b};
         default: alu_res = '0;
      endcase
   end

endmodule
`default_nettype wire

/* hdl/busy_time_window_meter.sv */
// Top level of the busy-time window meter: sequencer, state and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "busy_time_window_meter_macros.svh"
// Busy-time window meter. Each request carries an event kind (start, end,
// interval update, read only) and a 48-bit millisecond timestamp; each request
// returns exactly one response with all readings taken after the event. A
// start or read-only request goes straight to the response; an end request
// with a measurement open first takes the elapsed times and updates the sums
// and the max; an update does the same when a measurement is open and then
// runs the window sum update and the restoring divide of the 36-bit window sum
// by the 7-bit divisor (interval seconds times filled slots), one quotient
// bit per cycle, on the single shared 48-bit add/subtract unit with carry out
// that also computes every elapsed time, saturating sum and max compare. A
// finished response waits while a previous one still waits for rsp_ready. The
// block handles one request at a time; req_ready is high only while the
// sequencer is idle, and a finished response sits in an output register so the
// next request can be accepted while it waits for rsp_ready. The sixteen
// per-interval slot sums live in a small memory with a registered read; slots
// not yet written since reset read as zero through the window-filled flag.
module busy_time_window_meter
   import btwm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [KIND_W-1:0]    req_kind,
   input  wire logic [TIME_W-1:0]    req_timestamp_ms,

   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [AVG_W-1:0]          rsp_busy_per_second,
   output logic [BUSY_W-1:0]         rsp_last_interval_max_ms,
   output logic [TIME_W-1:0]         rsp_accumulated_busy_ms,
   output logic [BUSY_W-1:0]         rsp_interval_busy_ms,
   output logic                      rsp_measuring
);

   localparam logic [BUSY_W-1:0] BUSY_SAT = '1;
   localparam logic [TIME_W-1:0] TIME_SAT = '1;

   // Sequencer
   state_type state_ff, state_in;

   // Captured request
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [TIME_W-1:0] now_ff, now_in;

   // Meter state
   logic              active_ff, active_in;
   logic [TIME_W-1:0] start_ff, start_in;
   logic [TIME_W-1:0] last_ff, last_in;
   logic [BUSY_W-1:0] ib_ff, ib_in;
   logic [BUSY_W-1:0] imax_ff, imax_in;
   logic [BUSY_W-1:0] pmax_ff, pmax_in;
   logic [TIME_W-1:0] total_ff, total_in;
   logic [WSUM_W-1:0] wsum_ff, wsum_in;
   logic [SLOT_W-1:0] ptr_ff, ptr_in;
   logic              filled_ff, filled_in;
   logic [AVG_W-1:0]  avg_ff, avg_in;

   // Scratch for one event
   logic [TIME_W-1:0] inc_ff, inc_in;
   logic [BUSY_W-1:0] meas_ff, meas_in;
   logic [DIV_W-1:0]  divisor_ff, divisor_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [WSUM_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   // Response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [AVG_W-1:0]  rsp_avg_ff, rsp_avg_in;
   logic [BUSY_W-1:0] rsp_pmax_ff, rsp_pmax_in;
   logic [TIME_W-1:0] rsp_total_ff, rsp_total_in;
   logic [BUSY_W-1:0] rsp_ib_ff, rsp_ib_in;
   logic              rsp_meas_ff, rsp_meas_in;

   // Slot memory
   logic [BUSY_W-1:0] slot_mem [WINDOW_SLOTS];
   logic [BUSY_W-1:0] slot_rd_ff;
   logic              slot_we;

   // Shared arithmetic unit
   alu_req_type       alu_req;
   logic [ALU_W:0]    alu_res;
   logic              alu_borrow;

   logic              accept;
   logic              rsp_load;
   logic [DIV_W:0]    div_shift;
   logic [FILL_W-1:0] fill_cnt;
   logic [BUSY_W-1:0] slot_old;

   btwm_alu u_alu (
      .alu_req (alu_req),
      .alu_res (alu_res)
   );

   assign alu_borrow = alu_res[ALU_W];
   assign accept     = req_valid && req_ready;
   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign div_shift  = {rem_ff, quo_ff[WSUM_W-1]};
   assign fill_cnt   = filled_ff ? FILL_W'(WINDOW_SLOTS) : FILL_W'(ptr_ff);
   // Slots ahead of the pointer have never been written until the window fills.
   assign slot_old   = filled_ff ? slot_rd_ff : '0;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if ((req_kind == KIND_END || req_kind == KIND_UPDATE) && active_ff) begin
                  state_in = ST_EL_LAST;
               end else if (req_kind == KIND_UPDATE) begin
                  state_in = ST_WIN_SUB;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_EL_LAST:   state_in = ST_EL_START;
         ST_EL_START:  state_in = ST_ADD_IB;
         ST_ADD_IB:    state_in = ST_ADD_TOTAL;
         ST_ADD_TOTAL: state_in = ST_MAX;
         ST_MAX:       state_in = (kind_ff == KIND_END) ? ST_DONE : ST_WIN_SUB;
         ST_WIN_SUB:   state_in = ST_WIN_ADD;
         ST_WIN_ADD:   state_in = ST_DIV_SET;
         ST_DIV_SET:   state_in = ST_DIV;
         ST_DIV:       state_in = (cnt_ff == '0) ? ST_CLAMP : ST_DIV;
         ST_CLAMP:     state_in = ST_DONE;
         ST_DONE:      state_in = rsp_load ? ST_IDLE : ST_DONE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs of the sequencer
   always_comb begin
      kind_in    = kind_ff;
      now_in     = now_ff;
      active_in  = active_ff;
      start_in   = start_ff;
      last_in    = last_ff;
      ib_in      = ib_ff;
      imax_in    = imax_ff;
      pmax_in    = pmax_ff;
      total_in   = total_ff;
      wsum_in    = wsum_ff;
      ptr_in     = ptr_ff;
      filled_in  = filled_ff;
      avg_in     = avg_ff;
      inc_in     = inc_ff;
      meas_in    = meas_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      cnt_in     = cnt_ff;
      slot_we    = 1'b0;
      alu_req.op = ALU_SUB;
      alu_req.a  = '0;
      alu_req.b  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in = req_kind;
               now_in  = req_timestamp_ms;
               // A start while measuring keeps the original times.
               if (req_kind == KIND_START && !active_ff) begin
                  active_in = 1'b1;
                  start_in  = req_timestamp_ms;
                  last_in   = req_timestamp_ms;
               end
            end
         end
         ST_EL_LAST: begin
            alu_req.a = now_ff;
            alu_req.b = last_ff;
            // Time going backwards counts as zero.
            inc_in    = alu_borrow ? '0 : alu_res[TIME_W-1:0];
         end
         ST_EL_START: begin
            alu_req.a = now_ff;
            alu_req.b = start_ff;
            if (alu_borrow) begin
               meas_in = '0;
            end else if (|alu_res[TIME_W-1:BUSY_W]) begin
               meas_in = BUSY_SAT;
            end else begin
               meas_in = alu_res[BUSY_W-1:0];
            end
         end
         ST_ADD_IB: begin
            alu_req.op = ALU_ADD;
            alu_req.a  = ALU_W'(ib_ff);
            alu_req.b  = inc_ff;
            ib_in      = (|alu_res[ALU_W:BUSY_W]) ? BUSY_SAT : alu_res[BUSY_W-1:0];
         end
         ST_ADD_TOTAL: begin
            alu_req.op = ALU_ADD;
            alu_req.a  = total_ff;
            alu_req.b  = inc_ff;
            total_in   = alu_res[ALU_W] ? TIME_SAT : alu_res[TIME_W-1:0];
         end
         ST_MAX: begin
            alu_req.a = ALU_W'(imax_ff);
            alu_req.b = ALU_W'(meas_ff);
            if (alu_borrow) begin
               imax_in = meas_ff;
            end
            if (kind_ff == KIND_END) begin
               active_in = 1'b0;
               start_in  = '0;
               last_in   = '0;
            end else begin
               last_in   = now_ff;
            end
         end
         ST_WIN_SUB: begin
            alu_req.a = ALU_W'(wsum_ff);
            alu_req.b = ALU_W'(slot_old);
            wsum_in   = alu_res[WSUM_W-1:0];
         end
         ST_WIN_ADD: begin
            alu_req.op = ALU_ADD;
            alu_req.a  = ALU_W'(wsum_ff);
            alu_req.b  = ALU_W'(ib_ff);
            wsum_in    = alu_res[WSUM_W-1:0];
            slot_we    = 1'b1;
            if (ptr_ff == SLOT_W'(WINDOW_SLOTS - 1)) begin
               filled_in = 1'b1;
               ptr_in    = '0;
            end else begin
               ptr_in    = ptr_ff + SLOT_W'(1);
            end
         end
         ST_DIV_SET: begin
            divisor_in = DIV_W'(DIV_W'(INTERVAL_SECONDS) * DIV_W'(fill_cnt));
            rem_in     = '0;
            quo_in     = wsum_ff;
            cnt_in     = CNT_W'(WSUM_W - 1);
         end
         ST_DIV: begin
            // One restoring step: shift in the next dividend bit, try subtract.
            alu_req.a = ALU_W'(div_shift);
            alu_req.b = ALU_W'(divisor_ff);
            if (alu_borrow) begin
               rem_in = div_shift[DIV_W-1:0];
            end else begin
               rem_in = alu_res[DIV_W-1:0];
            end
            quo_in = {quo_ff[WSUM_W-2:0], !alu_borrow};
            cnt_in = cnt_ff - CNT_W'(1);
         end
         ST_CLAMP: begin
            avg_in  = (quo_ff > WSUM_W'(AVG_MAX)) ? AVG_W'(AVG_MAX) : quo_ff[AVG_W-1:0];
            pmax_in = imax_ff;
            ib_in   = '0;
            imax_in = '0;
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // Response register: load on finish, drop valid once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_avg_in   = rsp_avg_ff;
      rsp_pmax_in  = rsp_pmax_ff;
      rsp_total_in = rsp_total_ff;
      rsp_ib_in    = rsp_ib_ff;
      rsp_meas_in  = rsp_meas_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_avg_in   = avg_ff;
         rsp_pmax_in  = pmax_ff;
         rsp_total_in = total_ff;
         rsp_ib_in    = ib_ff;
         rsp_meas_in  = active_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 1'b0;
         start_ff     <= '0;
         last_ff      <= '0;
         ib_ff        <= '0;
         imax_ff      <= '0;
         pmax_ff      <= '0;
         total_ff     <= '0;
         wsum_ff      <= '0;
         ptr_ff       <= '0;
         filled_ff    <= 1'b0;
         avg_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         start_ff     <= start_in;
         last_ff      <= last_in;
         ib_ff        <= ib_in;
         imax_ff      <= imax_in;
         pmax_ff      <= pmax_in;
         total_ff     <= total_in;
         wsum_ff      <= wsum_in;
         ptr_ff       <= ptr_in;
         filled_ff    <= filled_in;
         avg_ff       <= avg_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers and scratch registers other than the divide count hold no reset.
   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      now_ff       <= now_in;
      inc_ff       <= inc_in;
      meas_ff      <= meas_in;
      divisor_ff   <= divisor_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      rsp_avg_ff   <= rsp_avg_in;
      rsp_pmax_ff  <= rsp_pmax_in;
      rsp_total_ff <= rsp_total_in;
      rsp_ib_ff    <= rsp_ib_in;
      rsp_meas_ff  <= rsp_meas_in;
   end

   // Slot sums: write the closing interval, read the slot under the pointer.
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[ptr_ff] <= ib_ff;
      end
      slot_rd_ff <= slot_mem[ptr_ff];
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_busy_per_second      = rsp_avg_ff;
   assign rsp_last_interval_max_ms = rsp_pmax_ff;
   assign rsp_accumulated_busy_ms  = rsp_total_ff;
   assign rsp_interval_busy_ms     = rsp_ib_ff;
   assign rsp_measuring            = rsp_meas_ff;

   // A start request always leaves a measurement open.
   `BTWM_ASSERT_NEXT(a_start_opens, clock, reset, accept && (req_kind == KIND_START), active_ff)
   // The stored average never leaves the clamp range.
   `BTWM_ASSERT_SAME(a_avg_range, clock, reset, 1'b1, avg_ff <= AVG_W'(AVG_MAX))
   // Finishing a request presents a response and frees the input side.
   `BTWM_ASSERT_NEXT(a_done_resp, clock, reset, rsp_load, rsp_valid && req_ready)

endmodule
`default_nettype wire
